FILE: design/dlr_pkg.sv
// shared types, codes and sizing helpers of the line rasterizer
package dlr_pkg;

  // command codes on the input channel
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  // front end sequencer states
  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_e;

  // entries held between front and back
  localparam int QueueDepth = 2;

  // increment: sign, one integer bit, fraction
  function automatic int inc_width(input int frac_bits);
    return frac_bits + 2;
  endfunction

  // queue entry: kind, start x, start y, increment x, increment y, steps
  function automatic int entry_width(input int coord_bits, input int frac_bits);
    return 1 + 3 * coord_bits + 2 * inc_width(frac_bits);
  endfunction

endpackage

FILE: design/dlr_if.sv
// command and pixel channel interfaces
interface dlr_cmd_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;

  modport source (output valid, command, x_start, y_start, x_end, y_end, input ready);
  modport sink (input valid, command, x_start, y_start, x_end, y_end, output ready);
endinterface

interface dlr_pix_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

FILE: design/dlr_front.sv
// front end: takes commands, sets up lines with a bit-serial divider
module dlr_front
  import dlr_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  dlr_cmd_if.sink                                    cmd_i,
  output logic                                       push_valid_o,
  input  logic                                       push_ready_i,
  output logic [entry_width(COORD_BITS, FRAC_BITS)-1:0] push_data_o
);

  localparam int IncW  = inc_width(FRAC_BITS);
  localparam int NumW  = COORD_BITS + FRAC_BITS;
  localparam int CntW  = $clog2(NumW);

  typedef struct packed {
    cmd_e                    kind;
    logic [COORD_BITS-1:0]   xs;
    logic [COORD_BITS-1:0]   ys;
    logic [IncW-1:0]         inc_x;
    logic [IncW-1:0]         inc_y;
    logic [COORD_BITS-1:0]   steps;
  } entry_t;

  fe_state_e             state_q, state_d;
  logic [COORD_BITS-1:0] xs_q, ys_q, steps_q;
  logic                  neg_x_q, neg_y_q;
  logic [NumW-1:0]       num_x_q, num_y_q;
  logic [COORD_BITS-1:0] rem_x_q, rem_y_q;
  logic [CntW-1:0]       cnt_q, cnt_d;

  logic                  accept;
  logic                  take_start;
  logic [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS:0]   adx_w, ady_w;
  logic [COORD_BITS-1:0] adx, ady, steps_w;
  logic [COORD_BITS:0]   shift_x, shift_y;
  logic                  ge_x, ge_y;
  logic [COORD_BITS:0]   sub_x, sub_y;
  logic [IncW-1:0]       mag_x, mag_y;
  entry_t                entry;

  assign cmd_i.ready = (state_q == FE_IDLE) && push_ready_i;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign take_start  = accept && (cmd_e'(cmd_i.command) == CMD_START);

  // endpoint deltas and their magnitudes
  assign dx     = {cmd_i.x_end[COORD_BITS-1], cmd_i.x_end}
                - {cmd_i.x_start[COORD_BITS-1], cmd_i.x_start};
  assign dy     = {cmd_i.y_end[COORD_BITS-1], cmd_i.y_end}
                - {cmd_i.y_start[COORD_BITS-1], cmd_i.y_start};
  assign adx_w  = dx[COORD_BITS] ? -dx : dx;
  assign ady_w  = dy[COORD_BITS] ? -dy : dy;
  assign adx    = adx_w[COORD_BITS-1:0];
  assign ady    = ady_w[COORD_BITS-1:0];
  assign steps_w = (adx > ady) ? adx : ady;

  // one quotient bit per cycle on each axis
  assign shift_x = {rem_x_q, num_x_q[NumW-1]};
  assign shift_y = {rem_y_q, num_y_q[NumW-1]};
  assign ge_x    = shift_x >= {1'b0, steps_q};
  assign ge_y    = shift_y >= {1'b0, steps_q};
  assign sub_x   = ge_x ? shift_x - {1'b0, steps_q} : shift_x;
  assign sub_y   = ge_y ? shift_y - {1'b0, steps_q} : shift_y;

  // quotient never exceeds one, so it fits in the fraction plus one bit
  assign mag_x = {1'b0, num_x_q[FRAC_BITS:0]};
  assign mag_y = {1'b0, num_y_q[FRAC_BITS:0]};

  always_comb begin
    entry = '0;
    if (state_q == FE_PUSH) begin
      entry.kind  = CMD_START;
      entry.xs    = xs_q;
      entry.ys    = ys_q;
      entry.inc_x = neg_x_q ? -mag_x : mag_x;
      entry.inc_y = neg_y_q ? -mag_y : mag_y;
      entry.steps = steps_q;
    end else begin
      entry.kind  = CMD_STEP;
    end
  end

  assign push_data_o  = entry;
  assign push_valid_o = (state_q == FE_PUSH)
                     || (accept && (cmd_e'(cmd_i.command) == CMD_STEP));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      FE_IDLE: begin
        cnt_d = '0;
        if (take_start) begin
          state_d = (steps_w == '0) ? FE_PUSH : FE_DIV;
        end
      end
      FE_DIV: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(NumW - 1)) begin
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (push_ready_i) begin
          state_d = FE_IDLE;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_start) begin
      xs_q    <= cmd_i.x_start;
      ys_q    <= cmd_i.y_start;
      steps_q <= steps_w;
      neg_x_q <= dx[COORD_BITS];
      neg_y_q <= dy[COORD_BITS];
      num_x_q <= {adx, {FRAC_BITS{1'b0}}};
      num_y_q <= {ady, {FRAC_BITS{1'b0}}};
      rem_x_q <= '0;
      rem_y_q <= '0;
    end else if (state_q == FE_DIV) begin
      num_x_q <= {num_x_q[NumW-2:0], ge_x};
      num_y_q <= {num_y_q[NumW-2:0], ge_y};
      rem_x_q <= sub_x[COORD_BITS-1:0];
      rem_y_q <= sub_y[COORD_BITS-1:0];
    end
  end

endmodule

FILE: design/dlr_queue.sv
// small queue between the front end and the pixel stepper
module dlr_queue
  import dlr_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [WIDTH-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != CntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/dlr_back.sv
// back end: holds the line state and steps one pixel per transfer
module dlr_back
  import dlr_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          pop_valid_i,
  output logic                                          pop_ready_o,
  input  logic [entry_width(COORD_BITS, FRAC_BITS)-1:0] pop_data_i,
  dlr_pix_if.source                                     pix_o
);

  localparam int IncW = inc_width(FRAC_BITS);
  localparam int PosW = COORD_BITS + FRAC_BITS;
  localparam logic [PosW-1:0] Half = PosW'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    cmd_e                    kind;
    logic [COORD_BITS-1:0]   xs;
    logic [COORD_BITS-1:0]   ys;
    logic [IncW-1:0]         inc_x;
    logic [IncW-1:0]         inc_y;
    logic [COORD_BITS-1:0]   steps;
  } entry_t;

  entry_t                entry;
  logic [PosW-1:0]       pos_x_q, pos_y_q;
  logic [IncW-1:0]       inc_x_q, inc_y_q;
  logic [COORD_BITS-1:0] left_q;
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic                  out_last_q;

  logic                  slot_free;
  logic                  is_step, emit, take;
  logic [PosW-1:0]       rnd_x, rnd_y;

  assign entry     = entry_t'(pop_data_i);
  assign slot_free = !out_valid_q || pix_o.ready;
  assign is_step   = entry.kind == CMD_STEP;
  // a step with nothing left is dropped without needing the output slot
  assign pop_ready_o = !is_step || (left_q == '0) || slot_free;
  assign take        = pop_valid_i && pop_ready_o;
  assign emit        = take && is_step && (left_q != '0);

  // round to nearest, ties toward plus infinity
  assign rnd_x = pos_x_q + Half;
  assign rnd_y = pos_y_q + Half;

  assign pix_o.valid      = out_valid_q;
  assign pix_o.pixel_x    = out_x_q;
  assign pix_o.pixel_y    = out_y_q;
  assign pix_o.last_pixel = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      inc_x_q     <= '0;
      inc_y_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take && !is_step) begin
        pos_x_q <= {entry.xs, {FRAC_BITS{1'b0}}};
        pos_y_q <= {entry.ys, {FRAC_BITS{1'b0}}};
        inc_x_q <= entry.inc_x;
        inc_y_q <= entry.inc_y;
        left_q  <= entry.steps;
      end else if (emit) begin
        pos_x_q <= pos_x_q + {{(PosW-IncW){inc_x_q[IncW-1]}}, inc_x_q};
        pos_y_q <= pos_y_q + {{(PosW-IncW){inc_y_q[IncW-1]}}, inc_y_q};
        left_q  <= left_q - COORD_BITS'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_x_q    <= rnd_x[PosW-1:FRAC_BITS];
      out_y_q    <= rnd_y[PosW-1:FRAC_BITS];
      out_last_q <= left_q == COORD_BITS'(1);
    end
  end

endmodule

FILE: design/dda_line_rasterizer.sv
// DDA line rasterizer top level
//
// A start command takes two endpoints and sets up a line of max(|dx|, |dy|)
// pixels; each step command then yields one pixel (start point included, end
// point excluded, the final one flagged by last_pixel) and a step with no line
// left yields nothing. Step commands pass at one per cycle while the queue has
// room. After a start command transfers, ready stays low while a bit-serial
// divider forms both axis increments, one quotient bit per cycle, and then
// while the line is handed to the queue. A zero-length start skips the
// divider and goes straight to the hand-off. A two-entry queue sits between
// command setup and pixel stepping, and pixels leave through an output
// register, so the command side keeps moving while a pixel waits to transfer;
// outside line setup, commands stall only once the queue is full.
module dda_line_rasterizer
  import dlr_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dlr_cmd_if.sink   cmd_i,
  dlr_pix_if.source pix_o
);

  localparam int EntryW = entry_width(COORD_BITS, FRAC_BITS);

  logic              push_valid, push_ready;
  logic [EntryW-1:0] push_data;
  logic              pop_valid, pop_ready;
  logic [EntryW-1:0] pop_data;

  dlr_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  dlr_queue #(
    .WIDTH (EntryW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  dlr_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .pix_o       (pix_o)
  );

endmodule
